// ----- hw/rtl/sart_pkg.sv -----
`default_nettype none
package sart_pkg;
   localparam int Capacity = 256;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = IdxW + 1;
   localparam int AddrW = 32;
   localparam int QueueDepth = 2;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_REPLY = 2'd1;
   localparam logic [1:0] MODE_SEND_FAIL = 2'd2;
   localparam logic [1:0] MODE_FINAL = 2'd3;

   localparam logic [2:0] ST_PENDING = 3'd0;
   localparam logic [2:0] ST_OK = 3'd1;
   localparam logic [2:0] ST_SEND_FAIL = 3'd2;
   localparam logic [2:0] ST_ERROR = 3'd3;
   localparam logic [2:0] ST_NO_REPLY = 3'd4;

   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_OWN_ID = 1'b1;

   // Decoded command handed from the front end to the table engine.
   typedef struct packed {
      logic [1:0] mode;
      logic [AddrW-1:0] address;
      logic [7:0] entry_index;
      logic good_reply;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_FIN_RD,
      S_FIN_WR,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/sart_front.sv -----
`default_nettype none
module sart_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [73:0] req_tdata,
   input wire logic [15:0] own_id,
   output logic cmd_valid,
   input wire logic cmd_ready,
   output sart_pkg::cmd_type cmd
);
   sart_pkg::cmd_type q_ff [sart_pkg::QueueDepth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   sart_pkg::cmd_type cls;
   logic push, pop;

   // Classify the reply check up front so the engine only sees a flag.
   always_comb begin
      cls.mode = req_tdata[1:0];
      cls.address = req_tdata[33:2];
      cls.entry_index = req_tdata[41:34];
      cls.good_reply = (req_tdata[57:42] == own_id) && (req_tdata[65:58] == 8'd0)
         && (req_tdata[73:66] == 8'd0);
   end

   assign req_tready = (fill_ff != 2'(sart_pkg::QueueDepth));
   assign push = req_tvalid && req_tready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(sart_pkg::QueueDepth)) else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) |-> !cmd_valid) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1) else $error("fill lost");
endmodule
`default_nettype wire

// ----- hw/rtl/sart_engine.sv -----
`default_nettype none
module sart_engine (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   output logic cmd_ready,
   input wire sart_pkg::cmd_type cmd,
   input wire logic [8:0] max_entries,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [63:0] rsp_tdata
);
   localparam int IW = sart_pkg::IdxW;
   localparam int CW = sart_pkg::CntW;

   logic [sart_pkg::AddrW-1:0] addr_mem [sart_pkg::Capacity];
   logic [2:0] stat_mem [sart_pkg::Capacity];
   logic [sart_pkg::AddrW-1:0] addr_rd_ff;
   logic [2:0] stat_rd_ff;

   sart_pkg::state_type state_ff, state_in;
   sart_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in;
   logic [CW-1:0] c_ok_ff, c_ok_in, c_err_ff, c_err_in, c_sf_ff, c_sf_in, c_nr_ff, c_nr_in;
   logic hit_ff, hit_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [2:0] fst_ff, fst_in;
   logic out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;

   // Memory control.
   logic rd_en;
   logic [IW-1:0] rd_addr;
   logic wa_en, ws_en;
   logic [IW-1:0] wr_addr;
   logic [sart_pkg::AddrW-1:0] wa_data;
   logic [2:0] ws_data;

   logic [CW-1:0] limit, mid, ins_pos;
   logic [2:0] st_fin;

   assign limit = (max_entries > 9'(sart_pkg::Capacity)) ? CW'(sart_pkg::Capacity)
      : CW'(max_entries);
   assign mid = lo_ff + ((hi_ff - lo_ff - 1'b1) >> 1);
   assign st_fin = (stat_rd_ff == sart_pkg::ST_PENDING) ? sart_pkg::ST_NO_REPLY : stat_rd_ff;
   assign cmd_ready = (state_ff == sart_pkg::S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   // Sequencer for search, shifted insert, marking and the finalize sweep.
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      count_in = count_ff;
      lo_in = lo_ff; hi_in = hi_ff; ptr_in = ptr_ff;
      c_ok_in = c_ok_ff; c_err_in = c_err_ff; c_sf_in = c_sf_ff; c_nr_in = c_nr_ff;
      hit_in = hit_ff; fidx_in = fidx_ff; fst_in = fst_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      rd_en = 1'b0; rd_addr = '0;
      wa_en = 1'b0; ws_en = 1'b0; wr_addr = '0; wa_data = cmd_ff.address;
      ws_data = sart_pkg::ST_PENDING;
      ins_pos = lo_ff;
      case (state_ff)
         sart_pkg::S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               hit_in = 1'b0; fidx_in = '0; fst_in = sart_pkg::ST_PENDING;
               c_ok_in = '0; c_err_in = '0; c_sf_in = '0; c_nr_in = '0;
               lo_in = '0; hi_in = count_ff; ptr_in = '0;
               case (cmd.mode)
                  sart_pkg::MODE_ADD: begin
                     state_in = (count_ff < limit) ? sart_pkg::S_SRCH_RD : sart_pkg::S_DONE;
                  end
                  sart_pkg::MODE_REPLY: state_in = sart_pkg::S_SRCH_RD;
                  sart_pkg::MODE_SEND_FAIL: begin
                     if ({1'b0, cmd.entry_index} < count_ff) begin
                        ws_en = 1'b1;
                        wr_addr = IW'(cmd.entry_index);
                        ws_data = sart_pkg::ST_SEND_FAIL;
                        hit_in = 1'b1;
                        fidx_in = IW'(cmd.entry_index);
                        fst_in = sart_pkg::ST_SEND_FAIL;
                     end
                     state_in = sart_pkg::S_DONE;
                  end
                  default: state_in = sart_pkg::S_FIN_RD;
               endcase
            end
         end
         sart_pkg::S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en = 1'b1;
               rd_addr = mid[IW-1:0];
               ptr_in = mid;
               state_in = sart_pkg::S_SRCH_CMP;
            end else if (cmd_ff.mode == sart_pkg::MODE_ADD) begin
               // Upper bound found in lo; shift the tail up from the end.
               ptr_in = count_ff;
               state_in = sart_pkg::S_SHIFT_RD;
            end else begin
               state_in = sart_pkg::S_DONE;
            end
         end
         sart_pkg::S_SRCH_CMP: begin
            state_in = sart_pkg::S_SRCH_RD;
            if (cmd_ff.mode == sart_pkg::MODE_ADD) begin
               if (addr_rd_ff <= cmd_ff.address) lo_in = ptr_ff + 1'b1;
               else hi_in = ptr_ff;
            end else if (addr_rd_ff == cmd_ff.address) begin
               ws_en = 1'b1;
               wr_addr = ptr_ff[IW-1:0];
               ws_data = cmd_ff.good_reply ? sart_pkg::ST_OK : sart_pkg::ST_ERROR;
               hit_in = 1'b1;
               fidx_in = ptr_ff[IW-1:0];
               fst_in = ws_data;
               state_in = sart_pkg::S_DONE;
            end else if (addr_rd_ff > cmd_ff.address) begin
               hi_in = ptr_ff;
            end else begin
               lo_in = ptr_ff + 1'b1;
            end
         end
         sart_pkg::S_SHIFT_RD: begin
            if (ptr_ff > lo_ff) begin
               rd_en = 1'b1;
               rd_addr = IW'(ptr_ff - 1'b1);
               state_in = sart_pkg::S_SHIFT_WR;
            end else begin
               state_in = sart_pkg::S_INSERT;
            end
         end
         sart_pkg::S_SHIFT_WR: begin
            wa_en = 1'b1; ws_en = 1'b1;
            wr_addr = ptr_ff[IW-1:0];
            wa_data = addr_rd_ff;
            ws_data = stat_rd_ff;
            ptr_in = ptr_ff - 1'b1;
            state_in = sart_pkg::S_SHIFT_RD;
         end
         sart_pkg::S_INSERT: begin
            wa_en = 1'b1; ws_en = 1'b1;
            wr_addr = ins_pos[IW-1:0];
            ws_data = sart_pkg::ST_PENDING;
            count_in = count_ff + 1'b1;
            hit_in = 1'b1;
            fidx_in = ins_pos[IW-1:0];
            fst_in = sart_pkg::ST_PENDING;
            state_in = sart_pkg::S_DONE;
         end
         sart_pkg::S_FIN_RD: begin
            if (ptr_ff < count_ff) begin
               rd_en = 1'b1;
               rd_addr = ptr_ff[IW-1:0];
               state_in = sart_pkg::S_FIN_WR;
            end else begin
               state_in = sart_pkg::S_DONE;
            end
         end
         sart_pkg::S_FIN_WR: begin
            ws_en = 1'b1;
            wr_addr = ptr_ff[IW-1:0];
            ws_data = st_fin;
            case (st_fin)
               sart_pkg::ST_OK: c_ok_in = c_ok_ff + 1'b1;
               sart_pkg::ST_ERROR: c_err_in = c_err_ff + 1'b1;
               sart_pkg::ST_SEND_FAIL: c_sf_in = c_sf_ff + 1'b1;
               sart_pkg::ST_NO_REPLY: c_nr_in = c_nr_ff + 1'b1;
               default: ;
            endcase
            ptr_in = ptr_ff + 1'b1;
            state_in = sart_pkg::S_FIN_RD;
         end
         sart_pkg::S_DONE: begin
            // Wait for the output register to free up.
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in = {7'd0, c_nr_ff, c_sf_ff, c_err_ff, c_ok_ff, count_ff, fst_ff,
                  8'(fidx_ff), hit_ff};
               state_in = sart_pkg::S_IDLE;
            end
         end
         default: state_in = sart_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sart_pkg::S_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      lo_ff <= lo_in; hi_ff <= hi_in; ptr_ff <= ptr_in;
      c_ok_ff <= c_ok_in; c_err_ff <= c_err_in; c_sf_ff <= c_sf_in; c_nr_ff <= c_nr_in;
      hit_ff <= hit_in; fidx_ff <= fidx_in; fst_ff <= fst_in;
      out_data_ff <= out_data_in;
   end

   // Table memories, one write and one registered read port each.
   always_ff @(posedge clock) begin
      if (wa_en) addr_mem[wr_addr] <= wa_data;
      if (ws_en) stat_mem[wr_addr] <= ws_data;
      if (rd_en) begin
         addr_rd_ff <= addr_mem[rd_addr];
         stat_rd_ff <= stat_mem[rd_addr];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sart_pkg::Capacity)) else $error("count past capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sart_pkg::S_INSERT) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not count");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != sart_pkg::S_INSERT) |=> count_ff == $past(count_ff))
      else $error("count changed outside insert");
endmodule
`default_nettype wire

// ----- hw/rtl/sorted_address_reply_table.sv -----
// Sorted address reply table. Each request transfer (add, reply, send failure,
// finalize) yields exactly one response transfer. A front end classifies requests
// into a two-entry queue; a table engine then works on one command at a time over
// table memories with one read and one write port. An add searches, shifts the
// tail up one entry at a time and inserts; a reply searches and marks; a send
// failure marks its entry directly; finalize sweeps every entry held through
// the one read port of the table memory.
`default_nettype none
module sorted_address_reply_table (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // mode[1:0], address[33:2], entry_index[41:34], reply_id[57:42],
   // reply_type[65:58], reply_code[73:66], zero fill to 80 bits
   input wire logic [79:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // hit[0], found_index[8:1], entry_status[11:9], total_entries[20:12],
   // count_ok[29:21], count_error[38:30], count_send_fail[47:39],
   // count_no_reply[56:48], zero fill to 64 bits
   output logic [63:0] rsp_tdata,
   input wire logic csr_we,
   input wire logic [0:0] csr_index,
   input wire logic [15:0] csr_wdata
);
   logic [8:0] max_entries_ff;
   logic [15:0] own_id_ff;
   logic cmd_valid, cmd_ready;
   sart_pkg::cmd_type cmd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= 9'd256;
         own_id_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sart_pkg::CSR_MAX_ENTRIES: max_entries_ff <= csr_wdata[8:0];
            sart_pkg::CSR_OWN_ID: own_id_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sart_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata[73:0]),
      .own_id(own_id_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   sart_engine u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
      .max_entries(max_entries_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One response as the table should report it.
   typedef struct {
      logic hit;
      logic [7:0] found_index;
      logic [2:0] entry_status;
      logic [8:0] total_entries;
      logic [8:0] count_ok;
      logic [8:0] count_error;
      logic [8:0] count_send_fail;
      logic [8:0] count_no_reply;
   } reply_fields_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic csr_we = 0;
   logic [0:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sorted_address_reply_table dut (.*);

   always #10 clock = ~clock;

   // Shadow copy of the table, its entry count and the registers.
   logic [31:0] shadow_addr[sart_pkg::Capacity];
   logic [2:0] shadow_status[sart_pkg::Capacity];
   int shadow_count = 0;
   int cfg_max_entries = 256;
   logic [15:0] cfg_own_id = '0;

   reply_fields_type expected_replies[$];
   int fail_count = 0;
   bit idle_on = 1;

   // Binary search with the lower midpoint over the half-open range.
   function automatic int search_table(logic [31:0] a);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + ((hi - 1 - lo) >> 1);
         if (shadow_addr[mid] == a) return mid;
         if (shadow_addr[mid] > a) hi = mid;
         else lo = mid + 1;
      end
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the response it causes.
   function automatic reply_fields_type apply_request(logic [1:0] m, logic [31:0] a,
         logic [7:0] ei, logic [15:0] rid, logic [7:0] rt, logic [7:0] rc);
      reply_fields_type r;
      int pos;
      int lim;
      r = '{default: '0};
      case (m)
         sart_pkg::MODE_ADD: begin
            lim = (cfg_max_entries < sart_pkg::Capacity) ? cfg_max_entries
                                                         : sart_pkg::Capacity;
            if (shadow_count < lim) begin
               pos = 0;
               while (pos < shadow_count && shadow_addr[pos] <= a) pos++;
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_addr[i] = shadow_addr[i-1];
                  shadow_status[i] = shadow_status[i-1];
               end
               shadow_addr[pos] = a;
               shadow_status[pos] = sart_pkg::ST_PENDING;
               shadow_count++;
               r.hit = 1;
               r.found_index = pos[7:0];
               r.entry_status = sart_pkg::ST_PENDING;
            end
         end
         sart_pkg::MODE_REPLY: begin
            pos = search_table(a);
            if (pos >= 0) begin
               shadow_status[pos] = (rid == cfg_own_id && rt == 0 && rc == 0) ?
                                    sart_pkg::ST_OK : sart_pkg::ST_ERROR;
               r.hit = 1;
               r.found_index = pos[7:0];
               r.entry_status = shadow_status[pos];
            end
         end
         sart_pkg::MODE_SEND_FAIL: begin
            if (int'(ei) < shadow_count) begin
               shadow_status[ei] = sart_pkg::ST_SEND_FAIL;
               r.hit = 1;
               r.found_index = ei;
               r.entry_status = sart_pkg::ST_SEND_FAIL;
            end
         end
         default: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_status[i] == sart_pkg::ST_PENDING)
                  shadow_status[i] = sart_pkg::ST_NO_REPLY;
               case (shadow_status[i])
                  sart_pkg::ST_OK: r.count_ok++;
                  sart_pkg::ST_ERROR: r.count_error++;
                  sart_pkg::ST_SEND_FAIL: r.count_send_fail++;
                  sart_pkg::ST_NO_REPLY: r.count_no_reply++;
                  default: ;
               endcase
            end
         end
      endcase
      r.total_entries = shadow_count[8:0];
      return r;
   endfunction

   // Sends one request transfer and records the response it should cause.
   task automatic send_request(logic [1:0] m, logic [31:0] a, logic [7:0] ei,
         logic [15:0] rid, logic [7:0] rt, logic [7:0] rc);
      if (idle_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 15)) @(negedge clock);
      req_tdata = {6'b0, rc, rt, rid, ei, a, m};
      req_tvalid = 1;
      expected_replies.push_back(apply_request(m, a, ei, rid, rt, rc));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic send_reply(logic [31:0] a, logic [15:0] rid, logic [7:0] rt,
         logic [7:0] rc);
      send_request(sart_pkg::MODE_REPLY, a, 8'd0, rid, rt, rc);
   endtask

   // Waits until every response has arrived, then writes one register.
   task automatic write_csr(logic [0:0] idx, logic [15:0] val);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      if (idx == sart_pkg::CSR_MAX_ENTRIES) cfg_max_entries = val[8:0];
      else cfg_own_id = val;
   endtask

   // Random receiver stalls in bursts.
   int stall_left = 0;
   always @(negedge clock) begin
      if (!idle_on || reset) begin
         rsp_tready = 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready = (stall_left == 0);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15);
         rsp_tready = 0;
      end else begin
         rsp_tready = 1;
      end
   end

   task automatic report_field(string name, longint e, longint a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         fail_count++;
      end
   endtask

   // Each response transfer is checked against the oldest expected response.
   always @(posedge clock) begin
      reply_fields_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            e = expected_replies.pop_front();
            report_field("hit", e.hit, rsp_tdata[0]);
            report_field("found_index", e.found_index, rsp_tdata[8:1]);
            report_field("entry_status", e.entry_status, rsp_tdata[11:9]);
            report_field("total_entries", e.total_entries, rsp_tdata[20:12]);
            report_field("count_ok", e.count_ok, rsp_tdata[29:21]);
            report_field("count_error", e.count_error, rsp_tdata[38:30]);
            report_field("count_send_fail", e.count_send_fail, rsp_tdata[47:39]);
            report_field("count_no_reply", e.count_no_reply, rsp_tdata[56:48]);
         end
      end
   end

   // Extremes, every mode, duplicates, misses and bad replies.
   task automatic test_directed();
      send_request(sart_pkg::MODE_FINAL, 32'h0, 8'd0, 16'h0, 8'h0, 8'h0);
      send_reply(32'h0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_SEND_FAIL, 32'h0, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'hFFFF_FFFF, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h0000_0000, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h8000_0000, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h8000_0000, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h8000_0000, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h7FFF_FFFF, 8'd0, 16'h0, 8'h0, 8'h0);
      send_reply(32'h8000_0000, 16'h0, 8'h0, 8'h0);
      send_reply(32'hFFFF_FFFF, 16'h0001, 8'h0, 8'h0);
      send_reply(32'h0000_0000, 16'h0, 8'hFF, 8'h0);
      send_reply(32'h7FFF_FFFF, 16'h0, 8'h0, 8'hFF);
      send_reply(32'h1234_5678, 16'h0, 8'h0, 8'h0);
      // A reply on an entry that already has a status overwrites it.
      send_reply(32'h0000_0000, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_SEND_FAIL, 32'h0, 8'd3, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_SEND_FAIL, 32'h0, 8'd255, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_SEND_FAIL, 32'h0, 8'd6, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_FINAL, 32'h0, 8'd0, 16'h0, 8'h0, 8'h0);
      write_csr(sart_pkg::CSR_OWN_ID, 16'hFFFF);
      send_reply(32'h8000_0000, 16'hFFFF, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_FINAL, 32'h0, 8'd0, 16'h0, 8'h0, 8'h0);
   endtask

   // A lowered limit refuses adds and keeps the entries already held.
   task automatic test_limit();
      write_csr(sart_pkg::CSR_MAX_ENTRIES, 16'd0);
      send_request(sart_pkg::MODE_ADD, 32'h0000_0001, 8'd0, 16'h0, 8'h0, 8'h0);
      write_csr(sart_pkg::CSR_MAX_ENTRIES, 16'd8);
      repeat (3) send_request(sart_pkg::MODE_ADD, $urandom, 8'd0, 16'h0, 8'h0, 8'h0);
      send_reply(shadow_addr[0], cfg_own_id, 8'h0, 8'h0);
   endtask

   // Random traffic in phases with different register settings.
   task automatic test_random();
      logic [31:0] pool[16];
      logic [31:0] a;
      int pick;
      foreach (pool[i]) pool[i] = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(sart_pkg::CSR_MAX_ENTRIES, 16'(40 + 30 * phase));
         write_csr(sart_pkg::CSR_OWN_ID, (phase == 1) ? 16'h0 : 16'($urandom));
         for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               a = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 15)] : $urandom;
               send_request(sart_pkg::MODE_ADD, a, 8'($urandom), 16'($urandom),
                            8'($urandom), 8'($urandom));
            end else if (pick < 75) begin
               if (shadow_count > 0 && $urandom_range(0, 4) != 0)
                  a = shadow_addr[$urandom_range(0, shadow_count - 1)];
               else
                  a = $urandom;
               if ($urandom_range(0, 2) != 0)
                  send_reply(a, cfg_own_id, 8'h0, 8'h0);
               else
                  send_reply(a, ($urandom_range(0, 1) == 0) ? cfg_own_id : 16'($urandom),
                             8'($urandom_range(0, 1) * $urandom),
                             8'($urandom_range(0, 1) * $urandom));
            end else if (pick < 93) begin
               send_request(sart_pkg::MODE_SEND_FAIL, $urandom, 8'($urandom),
                            16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               send_request(sart_pkg::MODE_FINAL, $urandom, 8'($urandom), 16'($urandom),
                            8'($urandom), 8'($urandom));
            end
         end
      end
   endtask

   // Fill the table to capacity with the top limit, then touch the last slot.
   task automatic test_full_table();
      write_csr(sart_pkg::CSR_MAX_ENTRIES, 16'd256);
      while (shadow_count < sart_pkg::Capacity)
         send_request(sart_pkg::MODE_ADD, $urandom, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_ADD, 32'h5555_5555, 8'd0, 16'h0, 8'h0, 8'h0);
      send_request(sart_pkg::MODE_SEND_FAIL, 32'h0, 8'd255, 16'h0, 8'h0, 8'h0);
      send_reply(shadow_addr[128], cfg_own_id, 8'h0, 8'h0);
      send_reply(shadow_addr[255], cfg_own_id, 8'h1, 8'h0);
      send_request(sart_pkg::MODE_FINAL, 32'h0, 8'd0, 16'h0, 8'h0, 8'h0);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 0;
      test_directed();
      test_limit();
      test_random();
      idle_on = 0;
      test_full_table();
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("sorted_address_reply_table verification clean");
      else
         $display("sorted_address_reply_table verification failed");
      $finish;
   end

   // Run time limit.
   initial begin
      #60ms;
      $display("sorted_address_reply_table verification failed");
      $finish;
   end
endmodule
`default_nettype wire
